>>> hw/rtl/sspp_pkg.sv
// sspp_pkg: shared types and constants of the sensor status property parser
// used by sspp_front, sspp_queue, sspp_back and the top level
package sspp_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned IdW       = 11;
  localparam int unsigned LenW      = 5;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned QueueDepth = 4;

  // header bit 0 marks format B
  localparam int unsigned FmtBBit   = 0;

  localparam logic RecProperty = 1'b0;
  localparam logic RecEnd      = 1'b1;

  typedef enum logic [1:0] {
    PH_HDR_LO = 2'd0,
    PH_HDR_HI = 2'd1,
    PH_VALUE  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    END_CLEAN     = 2'd0,
    END_FORMAT_B  = 2'd1,
    END_TRUNCATED = 2'd2,
    END_LONE_BYTE = 2'd3
  } end_status_e;

  // one queue entry: what one accepted byte produced, a property and/or an end
  typedef struct packed {
    logic              has_prop;
    logic [IdW-1:0]    id;
    logic [LenW-1:0]   len;
    logic [ValueW-1:0] acc;
    logic              has_end;
    end_status_e       status;
  } entry_t;

endpackage

>>> hw/rtl/sspp_front.sv
// sspp_front: byte parser, walks the property headers and value bytes
// and pushes one entry per byte that yields a record; uses sspp_pkg
module sspp_front import sspp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] payload_byte_i,
  input  logic             final_byte_i,
  input  logic             full_i,
  output logic             push_o,
  output entry_t           entry_o
);

  phase_e            phase_q, phase_d;
  logic              halted_q, halted_d;
  end_status_e       cause_q, cause_d;
  logic [ByteW-1:0]  hdr_lo_q, hdr_lo_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   seen_q, seen_d;
  logic [ValueW-1:0] acc_q, acc_d;

  logic              accept;
  logic [2*ByteW-1:0] hdr;
  logic              is_fmt_b;
  logic [LenW-1:0]   seen_inc;
  logic              val_done;

  assign accept     = in_valid_i & ~full_i;
  assign in_stall_o = full_i;
  assign hdr        = {payload_byte_i, hdr_lo_q};
  assign is_fmt_b   = hdr[FmtBBit];
  assign seen_inc   = seen_q + LenW'(1);
  assign val_done   = (seen_inc == len_q);

  // next state
  always_comb begin
    phase_d  = phase_q;
    halted_d = halted_q;
    cause_d  = cause_q;
    if (accept) begin
      if (halted_q) begin
        if (final_byte_i) begin
          halted_d = 1'b0;
          cause_d  = END_CLEAN;
          phase_d  = PH_HDR_LO;
        end
      end else begin
        unique case (phase_q)
          PH_HDR_HI: begin
            if (final_byte_i) begin
              phase_d = PH_HDR_LO;
            end else if (is_fmt_b) begin
              halted_d = 1'b1;
              cause_d  = END_FORMAT_B;
            end else begin
              phase_d = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (val_done || final_byte_i) begin
              phase_d = PH_HDR_LO;
            end
          end
          default: begin
            phase_d = final_byte_i ? PH_HDR_LO : PH_HDR_HI;
          end
        endcase
      end
    end
  end

  // header and value datapath
  always_comb begin
    hdr_lo_d = hdr_lo_q;
    id_d     = id_q;
    len_d    = len_q;
    seen_d   = seen_q;
    acc_d    = acc_q;
    if (accept && !halted_q) begin
      unique case (phase_q)
        PH_HDR_HI: begin
          id_d   = hdr[2*ByteW-1:5];
          len_d  = {1'b0, hdr[4:1]} + LenW'(1);
          seen_d = '0;
          acc_d  = '0;
        end
        PH_VALUE: begin
          // only the first four value bytes are kept
          if (seen_q[LenW-1:2] == '0) begin
            acc_d = acc_q | (ValueW'(payload_byte_i) << {seen_q[1:0], 3'b000});
          end
          seen_d = seen_inc;
        end
        default: begin
          hdr_lo_d = payload_byte_i;
        end
      endcase
    end
  end

  // queue entry
  always_comb begin
    push_o           = 1'b0;
    entry_o.has_prop = 1'b0;
    entry_o.id       = id_q;
    entry_o.len      = len_q;
    entry_o.acc      = acc_d;
    entry_o.has_end  = 1'b0;
    entry_o.status   = END_CLEAN;
    if (accept) begin
      if (halted_q) begin
        entry_o.has_end = final_byte_i;
        entry_o.status  = cause_q;
      end else begin
        unique case (phase_q)
          PH_HDR_HI: begin
            entry_o.has_end = final_byte_i;
            entry_o.status  = is_fmt_b ? END_FORMAT_B : END_TRUNCATED;
          end
          PH_VALUE: begin
            entry_o.has_prop = val_done;
            entry_o.has_end  = final_byte_i;
            entry_o.status   = val_done ? END_CLEAN : END_TRUNCATED;
          end
          default: begin
            entry_o.has_end = final_byte_i;
            entry_o.status  = END_LONE_BYTE;
          end
        endcase
      end
      push_o = entry_o.has_prop | entry_o.has_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR_LO;
      halted_q <= 1'b0;
      cause_q  <= END_CLEAN;
      hdr_lo_q <= '0;
      id_q     <= '0;
      len_q    <= '0;
      seen_q   <= '0;
      acc_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      halted_q <= halted_d;
      cause_q  <= cause_d;
      hdr_lo_q <= hdr_lo_d;
      id_q     <= id_d;
      len_q    <= len_d;
      seen_q   <= seen_d;
      acc_q    <= acc_d;
    end
  end

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("front pushed into a full queue");

  a_push_has_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> (entry_o.has_prop || entry_o.has_end))
    else $error("front pushed an empty entry");

  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && entry_o.has_end) |=> (phase_q == PH_HDR_LO && !halted_q))
    else $error("parser did not restart after payload end");

endmodule

>>> hw/rtl/sspp_queue.sv
// sspp_queue: small entry queue between parser front and record back end
// register file with read and write pointers; uses sspp_pkg
module sspp_queue import sspp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("queue count beyond depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count missed a push");

endmodule

>>> hw/rtl/sspp_back.sv
// sspp_back: turns queue entries into output records, property first,
// end record after; holds the output register; uses sspp_pkg
module sspp_back import sspp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  entry_t                   head_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     record_kind_o,
  output logic [IdW-1:0]           property_id_o,
  output logic [LenW-1:0]          value_length_o,
  output logic [ValueW-1:0]        value_unsigned_o,
  output logic signed [ValueW-1:0] value_signed_o,
  output logic [1:0]               end_status_o
);

  logic              out_valid_q, out_valid_d;
  logic              prop_done_q, prop_done_d;
  logic              kind_q;
  logic [IdW-1:0]    id_q;
  logic [LenW-1:0]   len_q;
  logic [ValueW-1:0] vu_q, vs_q;
  logic [1:0]        status_q;

  logic              load;
  logic              take;
  logic              emit_end;
  logic [ValueW-1:0] vu, vs;

  assign load     = !out_valid_q || !out_stall_i;
  assign take     = load && !empty_i;
  assign emit_end = !head_i.has_prop || prop_done_q;
  assign pop_o    = take && (emit_end || !head_i.has_end);

  // value only for one, two or four byte lengths
  always_comb begin
    vu = '0;
    vs = '0;
    unique case (head_i.len)
      LenW'(1): begin
        vu = {24'b0, head_i.acc[7:0]};
        vs = {{24{head_i.acc[7]}}, head_i.acc[7:0]};
      end
      LenW'(2): begin
        vu = {16'b0, head_i.acc[15:0]};
        vs = {{16{head_i.acc[15]}}, head_i.acc[15:0]};
      end
      LenW'(4): begin
        vu = head_i.acc;
        vs = head_i.acc;
      end
      default: begin
        vu = '0;
        vs = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = load ? !empty_i : out_valid_q;
    prop_done_d = prop_done_q;
    if (take) begin
      prop_done_d = !emit_end && head_i.has_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prop_done_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      prop_done_q <= prop_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (emit_end) begin
        kind_q   <= RecEnd;
        id_q     <= '0;
        len_q    <= '0;
        vu_q     <= '0;
        vs_q     <= '0;
        status_q <= head_i.status;
      end else begin
        kind_q   <= RecProperty;
        id_q     <= head_i.id;
        len_q    <= head_i.len;
        vu_q     <= vu;
        vs_q     <= vs;
        status_q <= END_CLEAN;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign record_kind_o    = kind_q;
  assign property_id_o    = id_q;
  assign value_length_o   = len_q;
  assign value_unsigned_o = vu_q;
  assign value_signed_o   = $signed(vs_q);
  assign end_status_o     = status_q;

endmodule

>>> hw/rtl/sensor_status_property_parser.sv
// Sensor status property parser (format A marshalled property ids).
// Input channel: one payload byte per word (payload_byte_i, final_byte_i),
// handshake in_valid_i / in_stall_o; a word moves when valid is high and
// stall is low. Output channel: one record per word, out_valid_o / out_stall_i.
// A property record carries id, length and the value read little-endian both
// zero- and sign-extended (lengths 1, 2 and 4 only); each payload end gives
// an end record with its status, after the property record if one is due.
// Throughput: one byte per cycle while the queue is not full. The parser front
// pushes an entry into a four-deep queue for each byte that yields records;
// the back end drains one record per cycle while out_stall_i is low. Each
// entry is written into the queue, then its records into the output register.
// in_stall_o is high only while the queue is full; it does not follow
// out_stall_i in the same cycle, and a stalled output record holds.
// Reset clears the parser to expect a header low byte and empties the queue.
// After every end record the parser restarts on the next payload.
module sensor_status_property_parser import sspp_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [ByteW-1:0]         payload_byte_i,
  input  logic                     final_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     record_kind_o,
  output logic [IdW-1:0]           property_id_o,
  output logic [LenW-1:0]          value_length_o,
  output logic [ValueW-1:0]        value_unsigned_o,
  output logic signed [ValueW-1:0] value_signed_o,
  output logic [1:0]               end_status_o
);

  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t entry;
  entry_t head;

  sspp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .payload_byte_i (payload_byte_i),
    .final_byte_i   (final_byte_i),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (entry)
  );

  sspp_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  sspp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .record_kind_o    (record_kind_o),
    .property_id_o    (property_id_o),
    .value_length_o   (value_length_o),
    .value_unsigned_o (value_unsigned_o),
    .value_signed_o   (value_signed_o),
    .end_status_o     (end_status_o)
  );

endmodule
